// ===== hdl/adsr_pkg.sv =====
// Package: shared types, codes and constants of the ADSR envelope generator.
`timescale 1ns / 1ps

package adsr_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int TIME_W  = 32;
    localparam int TICKS_W = 24;
    localparam int LEVEL_W = 16;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W = 3;

    // Product of a time magnitude and a level magnitude
    localparam int PROD_W = TIME_W + LEVEL_W;
    // One quotient bit per divider step
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_W = $clog2(DIV_STEPS);

    // Input commands
    localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd4;

    // Configuration reset values
    localparam logic [TICKS_W-1:0] RST_ATTACK  = 24'd5280;
    localparam logic [TICKS_W-1:0] RST_DECAY   = 24'd480;
    localparam logic [TICKS_W-1:0] RST_RELEASE = 24'd9600;
    localparam logic [LEVEL_W-1:0] RST_START   = 16'd32768;
    localparam logic [LEVEL_W-1:0] RST_SUSTAIN = 16'd26214;

    // Envelope phases
    localparam logic [PHASE_W-1:0] PH_ATTACK  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_DECAY   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SUSTAIN = 2'd2;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 2'd3;

    // Full scale and the small-level floor, Q1.15
    localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 16'd32768;
    localparam logic [LEVEL_W-1:0] LEVEL_FLOOR = 16'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TIME_W-1:0] time_stamp;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] amplitude;
        logic [PHASE_W-1:0] phase;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic note_on;
        logic note_off;
        logic diff;
        logic sel;
        logic mul;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ===== hdl/adsr_ctrl.sv =====
// Controller: runs a query through difference, select, multiply, divide, output.
`timescale 1ns / 1ps

module adsr_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic [adsr_pkg::CMD_W-1:0]      i_command,
    output logic                            o_in_stall,
    input  adsr_pkg::t_dp_status            i_status,
    output adsr_pkg::t_dp_cmd               o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIFF = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [adsr_pkg::STEP_W-1:0]   r_step;
    logic [adsr_pkg::STEP_W-1:0]   n_step;
    logic                          accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture  = (i_command == adsr_pkg::CMD_QUERY);
                    o_cmd.note_on  = (i_command == adsr_pkg::CMD_NOTE_ON);
                    o_cmd.note_off = (i_command == adsr_pkg::CMD_NOTE_OFF);
                    if (i_command == adsr_pkg::CMD_QUERY) begin
                        n_state = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_SEL;
            end
            S_SEL: begin
                o_cmd.sel = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_step    = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == adsr_pkg::STEP_W'(adsr_pkg::DIV_STEPS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_OUT: begin
                // Hold until the output register can take the item
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ===== hdl/adsr_datapath.sv =====
// Datapath: configuration, note state, segment select, multiplier, divider, output register.
`timescale 1ns / 1ps

module adsr_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [adsr_pkg::TICKS_W-1:0]      i_cfg_data,
    input  adsr_pkg::t_in_item                i_in_item,
    input  adsr_pkg::t_dp_cmd                 i_cmd,
    output adsr_pkg::t_dp_status              o_status,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output adsr_pkg::t_out_item               o_out_item
);

    localparam int TW = adsr_pkg::TIME_W;
    localparam int KW = adsr_pkg::TICKS_W;
    localparam int LW = adsr_pkg::LEVEL_W;
    localparam int PW = adsr_pkg::PROD_W;
    localparam int CW = TW + 2;   // signed compare width for elapsed time
    localparam int SW = PW + 2;   // signed width of the final level

    // Configuration
    logic [KW-1:0] r_attack, r_decay, r_release;
    logic [LW-1:0] r_start, r_sustain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= adsr_pkg::RST_ATTACK;
            r_decay   <= adsr_pkg::RST_DECAY;
            r_release <= adsr_pkg::RST_RELEASE;
            r_start   <= adsr_pkg::RST_START;
            r_sustain <= adsr_pkg::RST_SUSTAIN;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                adsr_pkg::CFG_ATTACK:  r_attack  <= i_cfg_data;
                adsr_pkg::CFG_DECAY:   r_decay   <= i_cfg_data;
                adsr_pkg::CFG_RELEASE: r_release <= i_cfg_data;
                adsr_pkg::CFG_START:   r_start   <= i_cfg_data[LW-1:0];
                adsr_pkg::CFG_SUSTAIN: r_sustain <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // A zero duration counts as one tick
    logic [KW-1:0] dur_a, dur_d, dur_r;
    assign dur_a = (r_attack  == '0) ? KW'(1) : r_attack;
    assign dur_d = (r_decay   == '0) ? KW'(1) : r_decay;
    assign dur_r = (r_release == '0) ? KW'(1) : r_release;

    // Note state
    logic          r_gate;
    logic [TW-1:0] r_on_time, r_off_time, r_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate     <= 1'b0;
            r_on_time  <= '0;
            r_off_time <= '0;
        end else if (i_cmd.note_on) begin
            r_gate    <= 1'b1;
            r_on_time <= i_in_item.time_stamp;
        end else if (i_cmd.note_off) begin
            r_gate     <= 1'b0;
            r_off_time <= i_in_item.time_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_time <= i_in_item.time_stamp;
        end
    end

    // Elapsed time since the relevant note event, modulo 2^32
    logic [TW-1:0] r_elapsed;
    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_elapsed <= r_time - (r_gate ? r_on_time : r_off_time);
        end
    end

    // Segment select: level = base +/- (mag_a * mag_b) / divisor
    logic [TW-1:0]                r_mag_a;
    logic [LW-1:0]                r_mag_b;
    logic                         r_neg;
    logic [LW-1:0]                r_base;
    logic [KW-1:0]                r_div;
    logic [adsr_pkg::PHASE_W-1:0] r_phase;

    logic [TW-1:0]                n_mag_a;
    logic [LW-1:0]                n_mag_b;
    logic                         n_neg;
    logic [LW-1:0]                n_base;
    logic [KW-1:0]                n_div;
    logic [adsr_pkg::PHASE_W-1:0] n_phase;

    logic signed [CW-1:0] life_s;
    logic [KW:0]          ad_sum;
    logic [TW-1:0]        life_abs;
    logic [LW:0]          lvl_diff;
    logic [LW-1:0]        lvl_diff_abs;

    assign life_s       = $signed({{2{r_elapsed[TW-1]}}, r_elapsed});
    assign ad_sum       = {1'b0, dur_a} + {1'b0, dur_d};
    assign life_abs     = r_elapsed[TW-1] ? (~r_elapsed + 1'b1) : r_elapsed;
    assign lvl_diff     = {1'b0, r_sustain} - {1'b0, r_start};
    assign lvl_diff_abs = lvl_diff[LW] ? (~lvl_diff[LW-1:0] + 1'b1) : lvl_diff[LW-1:0];

    always_comb begin
        n_mag_a = life_abs;
        n_mag_b = r_sustain;
        n_neg   = ~r_elapsed[TW-1];
        n_base  = r_sustain;
        n_div   = dur_r;
        n_phase = adsr_pkg::PH_RELEASE;
        if (r_gate) begin
            if (life_s <= $signed({{(CW-KW){1'b0}}, dur_a})) begin
                n_mag_a = life_abs;
                n_mag_b = r_start;
                n_neg   = r_elapsed[TW-1];
                n_base  = '0;
                n_div   = dur_a;
                n_phase = adsr_pkg::PH_ATTACK;
            end else if (life_s <= $signed({{(CW-KW-1){1'b0}}, ad_sum})) begin
                n_mag_a = r_elapsed - {{(TW-KW){1'b0}}, dur_a};
                n_mag_b = lvl_diff_abs;
                n_neg   = lvl_diff[LW];
                n_base  = r_start;
                n_div   = dur_d;
                n_phase = adsr_pkg::PH_DECAY;
            end else begin
                // Zero product leaves the base untouched
                n_mag_a = '0;
                n_mag_b = '0;
                n_neg   = 1'b0;
                n_base  = r_sustain;
                n_div   = dur_a;
                n_phase = adsr_pkg::PH_SUSTAIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sel) begin
            r_mag_a <= n_mag_a;
            r_mag_b <= n_mag_b;
            r_neg   <= n_neg;
            r_base  <= n_base;
            r_div   <= n_div;
            r_phase <= n_phase;
        end
    end

    // Multiply into the quotient register, then restoring divide, one bit a step
    logic [PW-1:0] r_quo;
    logic [KW-1:0] r_rem;
    logic [KW:0]   rem_sh;
    logic          rem_ge;
    logic [KW:0]   rem_sub;

    assign rem_sh  = {r_rem, r_quo[PW-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_div});
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_quo <= r_mag_a * r_mag_b;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[PW-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sub[KW-1:0] : rem_sh[KW-1:0];
        end
    end

    // Final level with floor and saturation
    logic signed [SW-1:0] level;
    logic [LW-1:0]        amp;

    always_comb begin
        if (r_neg) begin
            level = $signed({{(SW-LW){1'b0}}, r_base}) - $signed({2'b00, r_quo});
        end else begin
            level = $signed({{(SW-LW){1'b0}}, r_base}) + $signed({2'b00, r_quo});
        end
        if (level <= $signed({{(SW-LW){1'b0}}, adsr_pkg::LEVEL_FLOOR})) begin
            amp = '0;
        end else if (level > $signed({{(SW-LW){1'b0}}, adsr_pkg::LEVEL_FULL})) begin
            amp = adsr_pkg::LEVEL_FULL;
        end else begin
            amp = level[LW-1:0];
        end
    end

    // Output register
    logic r_out_valid;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_item.amplitude <= amp;
            o_out_item.phase     <= r_phase;
        end
    end

endmodule

// ===== hdl/adsr_envelope_generator_top.sv =====
// Top level of the linear ADSR envelope generator.
`timescale 1ns / 1ps

// Usage
//   Input channel: i_in_valid / o_in_stall carry one item {command, time_stamp}.
//   Note-on and note-off items update the gate and the recorded time and give
//   no result; the block takes the next item in the following cycle.
//   A sample query gives one item {amplitude, phase} on o_out_valid / i_out_stall.
//   A query runs through elapsed time, segment select, multiply, 48 divider
//   steps and output load. The 48-step restoring divider, one quotient bit a
//   cycle, sets the pace: a query holds off the next item until it has loaded
//   its result, while note commands are taken back to back.
//   Results leave through an output register, so a new item is taken while a
//   finished result still waits. When the receiver stalls, the result holds
//   stable; a following query runs to its last stage and then holds there until
//   the register frees up, keeping o_in_stall high meanwhile.
//   Configuration: i_cfg_wr_en writes i_cfg_data into register i_cfg_index
//   (0 attack, 1 decay, 2 release, 3 start level, 4 sustain level); other
//   indexes are ignored. Write only while the block is idle.
//   Reset (i_rst_n low, synchronous): gate off, both recorded times zero,
//   registers to their defaults, no result pending.

module adsr_envelope_generator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [adsr_pkg::TICKS_W-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  adsr_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output adsr_pkg::t_out_item               o_out_item
);

    // Command and status between the sequencer and the arithmetic
    adsr_pkg::t_dp_cmd    dp_cmd;
    adsr_pkg::t_dp_status dp_status;

    adsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_item.command),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    adsr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== hdl/adsr_checker.sv =====
// Port checker for the ADSR envelope generator, bound to the top level.
`timescale 1ns / 1ps

module adsr_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [adsr_pkg::TICKS_W-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              o_in_stall,
    input  adsr_pkg::t_in_item                i_in_item,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  adsr_pkg::t_out_item               o_out_item
);

    // No result is pending right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // Amplitude stays within full scale and never sits on the floor band
    a_amp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.amplitude <= adsr_pkg::LEVEL_FULL) &&
                        ((o_out_item.amplitude == '0) ||
                         (o_out_item.amplitude > adsr_pkg::LEVEL_FLOOR)))
        else $error("amplitude out of range");

    // A query keeps the input side busy in the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.command == adsr_pkg::CMD_QUERY)
        |=> o_in_stall)
        else $error("input free right after a query");

    // A new result appears only at the end of query work
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid ##1 o_out_valid |-> $past(o_in_stall))
        else $error("result without query work");

endmodule

bind adsr_envelope_generator_top adsr_checker u_adsr_checker (.*);

// ===== tb/tb.sv =====
// Self-checking bench for the linear ADSR envelope generator: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
    import adsr_pkg::*;

    // Command code the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    // Margin left after the last owed result has come back
    localparam int TAIL_CYCLES = 60;
    localparam int N_SETTINGS  = 6;
    localparam int PHASE_ITEMS = 108;

    // One row of the directed table. Where typed is set, the row carries its
    // own expected result; otherwise the predictor supplies it.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [TIME_W-1:0]  stamp;
        logic               typed;
        logic [LEVEL_W-1:0] amp;
        logic [PHASE_W-1:0] ph;
    } t_row;

    // Runs with the reset register values: attack 5280, decay 480,
    // release 9600, start full scale, sustain 26214.
    localparam int N_ROWS = 25;
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        // gate clear after reset, note-off time zero
        '{CMD_QUERY,    32'h0000_0000, 1'b1, 16'd26214, PH_RELEASE},
        '{CMD_QUERY,    32'd9600,      1'b1, 16'd0,     PH_RELEASE},
        // query before the note-off time: saturates
        '{CMD_QUERY,    32'hFFFF_0000, 1'b1, 16'd32768, PH_RELEASE},
        // far past the release: negative, clamps to zero
        '{CMD_QUERY,    32'h7FFF_FFFF, 1'b1, 16'd0,     PH_RELEASE},
        '{CMD_NOTE_ON,  32'd1000,      1'b0, '0,        '0},
        // unknown command must leave the gate alone
        '{CMD_UNUSED,   32'hFFFF_FFFF, 1'b0, '0,        '0},
        '{CMD_QUERY,    32'd1000,      1'b1, 16'd0,     PH_ATTACK},
        // query before the note-on time: clamps to zero
        '{CMD_QUERY,    32'd999,       1'b1, 16'd0,     PH_ATTACK},
        '{CMD_QUERY,    32'd1001,      1'b0, '0,        '0},
        // attack and decay boundaries
        '{CMD_QUERY,    32'd6280,      1'b1, 16'd32768, PH_ATTACK},
        '{CMD_QUERY,    32'd6281,      1'b0, '0,        '0},
        '{CMD_QUERY,    32'd6760,      1'b1, 16'd26214, PH_DECAY},
        '{CMD_QUERY,    32'd6761,      1'b1, 16'd26214, PH_SUSTAIN},
        // signed elapsed time: small negative, most negative, most positive
        '{CMD_QUERY,    32'hFFFF_FFFF, 1'b1, 16'd0,     PH_ATTACK},
        '{CMD_QUERY,    32'h8000_03E8, 1'b1, 16'd0,     PH_ATTACK},
        '{CMD_QUERY,    32'h8000_03E7, 1'b1, 16'd26214, PH_SUSTAIN},
        '{CMD_NOTE_OFF, 32'd20000,     1'b0, '0,        '0},
        '{CMD_QUERY,    32'd20000,     1'b1, 16'd26214, PH_RELEASE},
        // last tick of the release lands on the small-level floor
        '{CMD_QUERY,    32'd29599,     1'b0, '0,        '0},
        '{CMD_QUERY,    32'd19999,     1'b0, '0,        '0},
        '{CMD_QUERY,    32'd29600,     1'b1, 16'd0,     PH_RELEASE},
        // time stamps that wrap around zero
        '{CMD_NOTE_ON,  32'hFFFF_FF00, 1'b0, '0,        '0},
        '{CMD_QUERY,    32'h0000_0100, 1'b0, '0,        '0},
        '{CMD_NOTE_OFF, 32'hFFFF_FFFF, 1'b0, '0,        '0},
        '{CMD_QUERY,    32'h0000_0000, 1'b0, '0,        '0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICKS_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    t_in_item             in_item;
    logic                 out_valid;
    logic                 out_stall;
    t_out_item            out_item;

    // Shadow copy of the block: registers, gate and recorded times
    logic [TICKS_W-1:0] atk_ticks;
    logic [TICKS_W-1:0] dcy_ticks;
    logic [TICKS_W-1:0] rel_ticks;
    logic [LEVEL_W-1:0] start_lvl;
    logic [LEVEL_W-1:0] sustain_lvl;
    logic               gate_held;
    logic [TIME_W-1:0]  t_on;
    logic [TIME_W-1:0]  t_off;

    // Envelope levels still owed by the block, oldest first
    t_out_item levels_due [$];

    int bad_count = 0;
    // Stretches without idle cycles on either side
    bit send_quiet;
    bit sink_quiet;

    always #5 clk = ~clk;

    adsr_envelope_generator_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // Level and phase at a given time stamp, from the shadow state.
    // All arithmetic in 64-bit signed, quotients truncate toward zero.
    function automatic t_out_item envelope_at(input logic [TIME_W-1:0] stamp);
        t_out_item         res;
        logic [TIME_W-1:0] delta;
        longint            span, a, d, r, st, su, level, floor_lvl, full_lvl;
        a = longint'(atk_ticks);
        d = longint'(dcy_ticks);
        r = longint'(rel_ticks);
        // a zero duration counts as one tick
        if (a == 0) a = 1;
        if (d == 0) d = 1;
        if (r == 0) r = 1;
        st = longint'(start_lvl);
        su = longint'(sustain_lvl);
        floor_lvl = longint'(LEVEL_FLOOR);
        full_lvl  = longint'(LEVEL_FULL);
        if (gate_held) begin
            delta = stamp - t_on;
            span  = longint'($signed(delta));
            if (span <= a) begin
                level     = (span * st) / a;
                res.phase = PH_ATTACK;
            end else if (span <= a + d) begin
                level     = ((span - a) * (su - st)) / d + st;
                res.phase = PH_DECAY;
            end else begin
                level     = su;
                res.phase = PH_SUSTAIN;
            end
        end else begin
            delta     = stamp - t_off;
            span      = longint'($signed(delta));
            level     = su - (span * su) / r;
            res.phase = PH_RELEASE;
        end
        // drop tiny and negative levels, saturate at full scale
        if (level <= floor_lvl) level = 0;
        if (level > full_lvl) level = full_lvl;
        res.amplitude = level[LEVEL_W-1:0];
        return res;
    endfunction

    // Offer one item after a random gap, hold it until taken, then track it.
    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] stamp,
                             input bit typed, input t_out_item typed_res);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= '{command: cmd, time_stamp: stamp};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        case (cmd)
            CMD_NOTE_ON: begin
                gate_held = 1'b1;
                t_on      = stamp;
            end
            CMD_NOTE_OFF: begin
                gate_held = 1'b0;
                t_off     = stamp;
            end
            CMD_QUERY: levels_due.push_back(typed ? typed_res : envelope_at(stamp));
            default: ;
        endcase
    endtask

    // Mostly queries, many aimed at the segment edges of the current note, with
    // note events, wild time stamps and ignored commands mixed in.
    task automatic push_random();
        int                pick, off, a, d, r;
        logic [TIME_W-1:0] base;
        t_out_item         none;
        none = '0;
        a    = int'(atk_ticks);
        d    = int'(dcy_ticks);
        r    = int'(rel_ticks);
        base = gate_held ? t_on : t_off;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            push_item(CMD_NOTE_ON, $urandom, 1'b0, none);
        end else if (pick < 16) begin
            push_item(CMD_NOTE_OFF, $urandom, 1'b0, none);
        end else if (pick < 19) begin
            push_item(CMD_UNUSED, $urandom, 1'b0, none);
        end else begin
            case ($urandom_range(0, 9))
                0: off = $urandom_range(0, 6) - 3;
                1: off = a + $urandom_range(0, 4) - 2;
                2: off = a + d + $urandom_range(0, 4) - 2;
                3: off = r + $urandom_range(0, 4) - 2;
                4: off = -$urandom_range(1, 5000);
                5, 6: off = $urandom_range(0, a + d + 8);
                7: off = $urandom_range(0, r + 8);
                default: off = $urandom;
            endcase
            push_item(CMD_QUERY, base + off, 1'b0, none);
        end
    endtask

    // Drop valid and wait until every owed level has come back, then let
    // the block run dry.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (levels_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICKS_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ATTACK:  atk_ticks   = data;
            CFG_DECAY:   dcy_ticks   = data;
            CFG_RELEASE: rel_ticks   = data;
            CFG_START:   start_lvl   = data[LEVEL_W-1:0];
            CFG_SUSTAIN: sustain_lvl = data[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    // Register settings walked by the random part, extremes first.
    task automatic load_setting(input int which);
        case (which)
            0: begin
                // zero durations and levels above full scale; upper data bits
                // of a level write are dropped
                write_reg(CFG_ATTACK,  24'd0);
                write_reg(CFG_DECAY,   24'd0);
                write_reg(CFG_RELEASE, 24'd0);
                write_reg(CFG_START,   24'hFF_FFFF);
                write_reg(CFG_SUSTAIN, 24'hFF_FFFF);
            end
            1: begin
                write_reg(CFG_ATTACK,  24'hFF_FFFF);
                write_reg(CFG_DECAY,   24'hFF_FFFF);
                write_reg(CFG_RELEASE, 24'hFF_FFFF);
                write_reg(CFG_START,   24'd0);
                write_reg(CFG_SUSTAIN, 24'd0);
            end
            2: begin
                write_reg(CFG_ATTACK,  24'd1);
                write_reg(CFG_DECAY,   24'd1);
                write_reg(CFG_RELEASE, 24'd1);
                write_reg(CFG_START,   {8'd0, LEVEL_FULL});
                write_reg(CFG_SUSTAIN, 24'd0);
            end
            3: begin
                write_reg(CFG_ATTACK,  TICKS_W'($urandom_range(1, 4000)));
                write_reg(CFG_DECAY,   TICKS_W'($urandom_range(0, 4000)));
                write_reg(CFG_RELEASE, TICKS_W'($urandom_range(1, 4000)));
                write_reg(CFG_START,   TICKS_W'($urandom_range(0, 32768)));
                write_reg(CFG_SUSTAIN, TICKS_W'($urandom_range(0, 32768)));
                // no register here: the write must change nothing
                write_reg(CFG_SPARE,   TICKS_W'($urandom));
            end
            4: begin
                // decay climbs from a low peak up to the sustain level
                write_reg(CFG_ATTACK,  TICKS_W'($urandom_range(1, 24'hFF_FFFF)));
                write_reg(CFG_DECAY,   TICKS_W'($urandom_range(1, 24'hFF_FFFF)));
                write_reg(CFG_RELEASE, TICKS_W'($urandom_range(1, 24'hFF_FFFF)));
                write_reg(CFG_START,   TICKS_W'($urandom_range(0, 16384)));
                write_reg(CFG_SUSTAIN, TICKS_W'($urandom_range(16385, 32768)));
            end
            default: begin
                write_reg(CFG_ATTACK,  RST_ATTACK);
                write_reg(CFG_DECAY,   RST_DECAY);
                write_reg(CFG_RELEASE, RST_RELEASE);
                write_reg(CFG_START,   {8'd0, RST_START});
                write_reg(CFG_SUSTAIN, {8'd0, RST_SUSTAIN});
            end
        endcase
    endtask

    // Result side: hold stall for a random count of cycles once a result
    // shows up, then take it and check it against the oldest owed level.
    initial begin : result_sink
        int        hold;
        t_out_item want;
        hold      = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (out_valid === 1'b1 && hold > 0) begin
                out_stall <= 1'b1;
                hold--;
            end else begin
                out_stall <= 1'b0;
            end
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall) begin
                if (levels_due.size() == 0) begin
                    $display("%0t: result with none owed, amplitude %0d phase %0d",
                             $time, out_item.amplitude, out_item.phase);
                    bad_count++;
                end else begin
                    want = levels_due.pop_front();
                    if (out_item.amplitude !== want.amplitude) begin
                        $display("%0t: amplitude expected %0d, got %0d",
                                 $time, want.amplitude, out_item.amplitude);
                        bad_count++;
                    end
                    if (out_item.phase !== want.phase) begin
                        $display("%0t: phase expected %0d, got %0d",
                                 $time, want.phase, out_item.phase);
                        bad_count++;
                    end
                end
                hold = sink_quiet ? 0 : $urandom_range(0, 9);
            end
        end
    end

    // Main sequence: reset, directed table, then one random phase per setting.
    initial begin : stimulus
        t_out_item row_res;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_item     = '0;
        send_quiet  = 1'b0;
        sink_quiet  = 1'b0;
        // mirror the reset state of the block
        atk_ticks   = RST_ATTACK;
        dcy_ticks   = RST_DECAY;
        rel_ticks   = RST_RELEASE;
        start_lvl   = RST_START;
        sustain_lvl = RST_SUSTAIN;
        gate_held   = 1'b0;
        t_on        = '0;
        t_off       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            row_res.amplitude = DIRECTED_ROWS[i].amp;
            row_res.phase     = DIRECTED_ROWS[i].ph;
            push_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].stamp,
                      DIRECTED_ROWS[i].typed, row_res);
        end
        settle();

        for (int p = 0; p < N_SETTINGS; p++) begin
            load_setting(p);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // switch idle behavior of both sides now and then
                if (k % 36 == 0) begin
                    send_quiet = ($urandom_range(0, 2) == 0);
                    sink_quiet = ($urandom_range(0, 2) == 0);
                end
                // halfway through, hold off until every owed level is back
                if (k == PHASE_ITEMS / 2) settle();
                push_random();
            end
            settle();
        end

        if (bad_count == 0) begin
            $display("[adsr_envelope_generator_top] OK");
        end else begin
            $display("[adsr_envelope_generator_top] ERROR");
        end
        $finish;
    end

    // Watchdog: several times the slowest correct run
    initial begin : watchdog
        #5_000_000;
        $display("[adsr_envelope_generator_top] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/adsr_pkg.sv
hdl/adsr_ctrl.sv
hdl/adsr_datapath.sv
hdl/adsr_envelope_generator_top.sv
hdl/adsr_checker.sv
tb/tb.sv
